// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/slt_pkg.sv =====
`default_nettype none

package slt_pkg;

    localparam int SETS    = 64;
    localparam int WAYS    = 8;
    localparam int ID_BITS = 32;

    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W  = $clog2(WAYS + 1);
    localparam int DEPTH  = SETS * WAYS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Fixed field widths of the request and response words and of cfg_wdata.
    localparam int KIND_W   = 2;
    localparam int SETF_W   = 6;
    localparam int IDF_W    = 32;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 4;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] WAYS_RESET = 4'd8;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_TOUCH  = 2'd1,
        KIND_EVICT  = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_ABSENT  = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_PRESENT = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OCC,
        S_SCAN,
        S_SHIFT,
        S_TAIL
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SETF_W-1:0] set_index;
        logic [IDF_W-1:0]  line_id;
    } req_t;

    typedef struct packed {
        logic [IDF_W-1:0]    evicted_id;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

    typedef struct packed {
        logic             we;
        logic [SET_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } occ_wr_t;

    function automatic logic [SET_W-1:0] set_of(input logic [SETF_W-1:0] v);
        return SET_W'(32'(v) % SETS);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_of(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        return ADDR_W'(s) * ADDR_W'(WAYS) + ADDR_W'(w);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/slt_ram.sv =====
`default_nettype none

module slt_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/slt_occ_store.sv =====
`default_nettype none

module slt_occ_store import slt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [SET_W-1:0] raddr,
    output logic [CNT_W-1:0] rdata,
    input  occ_wr_t          wr
);

    logic [CNT_W-1:0] mem [SETS];
    logic [SETS-1:0]  valid_reg;
    logic [CNT_W-1:0] data_reg;
    logic             vld_reg;

    // A set never written since reset reads as empty.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            vld_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        data_reg <= mem[raddr];
    end

    assign rdata = vld_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/set_associative_lru_tracker.sv =====
// True LRU recency tracker, one recency list per cache set.
// A request word (kind, set_index, line_id) is taken at a clock edge where
// start is high and busy is low. busy stays high until the response word is
// produced; done then pulses for one cycle with evicted_id, status and
// occupancy on rsp. The receiver cannot stall: the word is valid only in
// that cycle, and busy is already low so the next request may be taken.
// The recency lists sit in a single-port-read order memory that is streamed
// one entry per cycle: the search compares one stored identifier a cycle
// and the shift moves one entry a cycle. A request passes through OCC, which
// reads the set's count, and SCAN, which searches the list; an unused kind
// ends after OCC, and an insert, a miss or an evict from an empty set ends
// in SCAN. A touch or evict hit goes on through SHIFT and TAIL.
// ways_in_use is written through cfg_we/cfg_wdata; the user keeps such writes
// to while the block is idle, which the block itself does not enforce.
// Reset sets ways_in_use to 8 and marks every set empty; the order memory
// itself is not cleared, since only entries below a set's count are read.
`default_nettype none
`include "assert_macros.svh"

module set_associative_lru_tracker import slt_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             req,
    output logic             done,
    output rsp_t             rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    ways_reg;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SET_W-1:0]    set_reg, set_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [ID_BITS-1:0]  evicted_reg, evicted_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    cmp_ptr_reg, cmp_ptr_next;
    logic                cmp_vld_reg, cmp_vld_next;
    rsp_t                rsp_reg, rsp_next;
    logic                done_reg, done_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ID_BITS-1:0]  ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ID_BITS-1:0]  ram_rdata;

    occ_wr_t             occ_wr;
    logic [CNT_W-1:0]    occ_rdata;
    logic [CNT_W-1:0]    occ_fetch;
    logic [CNT_W-1:0]    limit;
    logic [CNT_W-1:0]    prev_ptr;
    logic                kind_known;
    logic                cmp_hit;
    logic                more;

    logic                fin;
    status_t             fin_status;
    logic [CNT_W-1:0]    fin_occ;

    slt_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ID_BITS)
    ) u_order (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    slt_occ_store u_occ (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (set_of(req.set_index)),
        .rdata (occ_rdata),
        .wr    (occ_wr)
    );

    function automatic logic [WAY_W-1:0] prev_occ_idx(input logic [CNT_W-1:0] n);
        logic [CNT_W-1:0] m;
        m = n - CNT_W'(1);
        return m[WAY_W-1:0];
    endfunction

    assign occ_fetch = (occ_rdata > CNT_W'(WAYS)) ? CNT_W'(WAYS) : occ_rdata;
    assign limit     = (32'(ways_reg) > WAYS) ? CNT_W'(WAYS) : CNT_W'(ways_reg);
    assign prev_ptr  = cmp_ptr_reg - CNT_W'(1);
    assign more      = ptr_reg < occ_reg;

    // An evict matches on the first entry it reads, which is the least recent.
    assign cmp_hit = cmp_vld_reg &&
                     ((kind_reg == KIND_EVICT) || (ram_rdata == id_reg));

    always_comb
    begin
        case (kind_reg)
            KIND_INSERT, KIND_TOUCH, KIND_EVICT: kind_known = 1'b1;
            default:                             kind_known = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_OCC;
                end
            end
            S_OCC:
            begin
                state_next = kind_known ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                if (cmp_hit)
                begin
                    state_next = (kind_reg == KIND_INSERT) ? S_IDLE : S_SHIFT;
                end
                else if (!more)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                if (!more)
                begin
                    state_next = S_TAIL;
                end
            end
            S_TAIL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        kind_next    = kind_reg;
        set_next     = set_reg;
        id_next      = id_reg;
        evicted_next = evicted_reg;
        occ_next     = occ_reg;
        ptr_next     = ptr_reg;
        cmp_ptr_next = cmp_ptr_reg;
        cmp_vld_next = cmp_vld_reg;
        rsp_next     = rsp_reg;
        ram_we       = 1'b0;
        ram_waddr    = addr_of(set_reg, occ_reg[WAY_W-1:0]);
        ram_wdata    = id_reg;
        ram_raddr    = addr_of(set_reg, ptr_reg[WAY_W-1:0]);
        fin          = 1'b0;
        fin_status   = STAT_OK;
        fin_occ      = occ_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = req.kind;
                    set_next     = set_of(req.set_index);
                    id_next      = ID_BITS'(req.line_id);
                    evicted_next = '0;
                end
            end
            S_OCC:
            begin
                occ_next     = occ_fetch;
                ptr_next     = '0;
                cmp_vld_next = 1'b0;
                if (!kind_known)
                begin
                    fin     = 1'b1;
                    fin_occ = occ_fetch;
                end
            end
            S_SCAN:
            begin
                if (cmp_hit)
                begin
                    cmp_vld_next = 1'b0;
                    ptr_next     = cmp_ptr_reg + CNT_W'(1);
                    if (kind_reg == KIND_EVICT)
                    begin
                        evicted_next = ram_rdata;
                    end
                    if (kind_reg == KIND_INSERT)
                    begin
                        fin        = 1'b1;
                        fin_status = STAT_PRESENT;
                    end
                end
                else if (more)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_ptr_next = ptr_reg;
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    fin = 1'b1;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (occ_reg >= limit)
                        begin
                            fin_status = STAT_FULL;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = addr_of(set_reg, occ_reg[WAY_W-1:0]);
                            ram_wdata = id_reg;
                            fin_occ   = occ_reg + CNT_W'(1);
                        end
                    end
                    else if (kind_reg == KIND_TOUCH)
                    begin
                        fin_status = STAT_ABSENT;
                    end
                    else
                    begin
                        fin_status = STAT_EMPTY;
                    end
                end
            end
            S_SHIFT:
            begin
                // Each entry read last cycle moves down one slot.
                if (cmp_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_of(set_reg, prev_ptr[WAY_W-1:0]);
                    ram_wdata = ram_rdata;
                end
                if (more)
                begin
                    cmp_vld_next = 1'b1;
                    cmp_ptr_next = ptr_reg;
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end
            S_TAIL:
            begin
                fin = 1'b1;
                if (kind_reg == KIND_TOUCH)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr_of(set_reg, prev_occ_idx(occ_reg));
                    ram_wdata = id_reg;
                end
                else
                begin
                    fin_occ = occ_reg - CNT_W'(1);
                end
            end
            default:
            begin
            end
        endcase

        occ_wr.we   = fin;
        occ_wr.addr = set_reg;
        occ_wr.data = fin_occ;
        done_next   = fin;
        if (fin)
        begin
            occ_next            = fin_occ;
            rsp_next.evicted_id = IDF_W'(evicted_reg);
            rsp_next.status     = fin_status;
            rsp_next.occupancy  = OCC_W'(fin_occ);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ways_reg    <= WAYS_RESET;
            cmp_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                ways_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg    <= kind_next;
        set_reg     <= set_next;
        id_reg      <= id_next;
        evicted_reg <= evicted_next;
        occ_reg     <= occ_next;
        ptr_reg     <= ptr_next;
        cmp_ptr_reg <= cmp_ptr_next;
        rsp_reg     <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLIES(a_done_after_work, clk, rst_n, done, $past(busy))
    `ASSERT_IMPLIES(a_occ_bound, clk, rst_n, done, 32'(rsp.occupancy) <= WAYS)
    `ASSERT_IMPLIES(a_write_while_busy, clk, rst_n, ram_we, busy)

endmodule

`default_nettype wire

// ===== tb/set_associative_lru_tracker_tb.sv =====
module set_associative_lru_tracker_tb import slt_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    // The package has no member for the spare operation code.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 1500;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int REPORT_LIMIT = 10;

    class recency_scoreboard;
        logic [IDF_W-1:0] recency [SETS][WAYS];
        int               fill [SETS];
        logic [CFG_W-1:0] ways_limit = WAYS_RESET;
        rsp_t             awaited_responses [$];
        int               failures = 0;

        function void report(string what, rsp_t want, rsp_t got);
            string want_s;
            string got_s;
            failures++;
            if (failures <= REPORT_LIMIT)
            begin
                want_s = $sformatf("evicted_id=%h status=%0d occupancy=%0d",
                                   want.evicted_id, want.status, want.occupancy);
                got_s  = $sformatf("evicted_id=%h status=%0d occupancy=%0d",
                                   got.evicted_id, got.status, got.occupancy);
                $display("%t: %s: expected %s, got %s", $realtime, what, want_s, got_s);
            end
        endfunction

        // Works out the response to an accepted request and advances the recency lists.
        function void note_request(req_t r);
            int   s;
            int   n;
            int   lim;
            int   pos;
            rsp_t e;
            s   = int'(r.set_index) % SETS;
            n   = fill[s];
            lim = (ways_limit > WAYS) ? WAYS : int'(ways_limit);
            pos = -1;
            for (int i = 0; i < n; i++)
                if (pos < 0 && recency[s][i] == r.line_id)
                    pos = i;
            e = '0;
            e.status = STAT_OK;
            case (r.kind)
                KIND_INSERT:
                    if (pos >= 0)
                        e.status = STAT_PRESENT;
                    else if (n >= lim)
                        e.status = STAT_FULL;
                    else
                    begin
                        recency[s][n] = r.line_id;
                        n++;
                    end
                KIND_TOUCH:
                    if (pos < 0)
                        e.status = STAT_ABSENT;
                    else
                    begin
                        for (int i = pos; i < n - 1; i++)
                            recency[s][i] = recency[s][i + 1];
                        recency[s][n - 1] = r.line_id;
                    end
                KIND_EVICT:
                    if (n == 0)
                        e.status = STAT_EMPTY;
                    else
                    begin
                        e.evicted_id = recency[s][0];
                        for (int i = 0; i < n - 1; i++)
                            recency[s][i] = recency[s][i + 1];
                        n--;
                    end
                default:
                    ;
            endcase
            fill[s] = n;
            e.occupancy = OCC_W'(n);
            awaited_responses = {awaited_responses, e};
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (awaited_responses.size() == 0)
            begin
                report("response word with no request outstanding", '0, got);
                return;
            end
            want = awaited_responses.pop_front();
            if (got.evicted_id !== want.evicted_id || got.status !== want.status ||
                got.occupancy !== want.occupancy)
                report("response mismatch", want, got);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    recency_scoreboard sb = new();
    bit                quiet_sender;
    int                cycles;

    set_associative_lru_tracker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("set_associative_lru_tracker verification failed");
            $finish;
        end
    end

    // These updates and the check use values sampled before this edge's updates.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.ways_limit = cfg_wdata;
            if (start && !busy)
                sb.note_request(req);
            if (done)
                sb.check_response(rsp);
        end
    end

    task automatic send_word(input req_t r);
        int gap;
        req   <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (!quiet_sender && $urandom_range(99) < 28)
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic issue(input logic [KIND_W-1:0] kind, input logic [SETF_W-1:0] set_index,
                         input logic [IDF_W-1:0] line_id);
        req_t r;
        r.kind      = kind;
        r.set_index = set_index;
        r.line_id   = line_id;
        send_word(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.awaited_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_ways_limit(input logic [CFG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int words);
        logic [SETF_W-1:0] hot_sets [4];
        logic [IDF_W-1:0]  id_pool [16];
        logic [KIND_W-1:0] kind;
        int                roll;
        int                counted;
        counted = 0;
        foreach (hot_sets[i])
            hot_sets[i] = SETF_W'($urandom);
        foreach (id_pool[i])
            id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;
        // A small pool of sets and block ids keeps hits, full sets and evicts frequent.
        while (counted < words)
        begin
            roll = $urandom_range(99);
            if (roll < 38)
                kind = KIND_INSERT;
            else if (roll < 68)
                kind = KIND_TOUCH;
            else if (roll < 96)
                kind = KIND_EVICT;
            else
                kind = KIND_UNUSED;
            issue(kind,
                  ($urandom_range(99) < 80) ? hot_sets[$urandom_range(3)] : SETF_W'($urandom),
                  ($urandom_range(99) < 85) ? id_pool[$urandom_range(15)] : $urandom);
            if (kind != KIND_UNUSED)
                counted++;
        end
    endtask

    initial
    begin
        logic [CFG_W-1:0] limits [8];
        limits = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0, 4'd6, 4'd9, 4'd8};
        cycles       = 0;
        quiet_sender = 1'b0;
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req          <= '0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Error cases on empty sets, the spare operation code and the id extremes, then set 63 filled past full.
        issue(KIND_EVICT, 6'd0, 32'h0);
        issue(KIND_TOUCH, 6'd63, 32'h0);
        issue(KIND_UNUSED, 6'd0, 32'hFFFF_FFFF);
        issue(KIND_INSERT, 6'd0, 32'h0);
        issue(KIND_INSERT, 6'd0, 32'hFFFF_FFFF);
        issue(KIND_INSERT, 6'd0, 32'hA5A5_A5A5);
        issue(KIND_INSERT, 6'd0, 32'h5A5A_5A5A);
        issue(KIND_INSERT, 6'd0, 32'h0);
        issue(KIND_TOUCH, 6'd0, 32'h0);
        issue(KIND_EVICT, 6'd0, 32'h0);
        for (int i = 0; i < WAYS; i++)
            issue(KIND_INSERT, 6'd63, 32'h1 << (4 * i));
        issue(KIND_INSERT, 6'd63, 32'h7FFF_FFFF);
        issue(KIND_TOUCH, 6'd63, 32'h1 << 12);

        // A zero limit makes every insert full; a limit below the occupancy keeps the blocks.
        set_ways_limit(4'd0);
        issue(KIND_INSERT, 6'd1, 32'h1);
        set_ways_limit(4'd2);
        issue(KIND_INSERT, 6'd63, 32'h2);
        issue(KIND_EVICT, 6'd63, 32'h0);
        set_ways_limit(4'd15);
        issue(KIND_INSERT, 6'd2, 32'h3);

        foreach (limits[p])
        begin
            set_ways_limit(limits[p]);
            quiet_sender = (p == 1);
            random_phase(RANDOM_WORDS / 8);
        end

        drain();
        repeat (2 * WAYS + 10) @(posedge clk);
        if (sb.awaited_responses.size() != 0)
        begin
            sb.failures++;
            $display("%0d responses never arrived", sb.awaited_responses.size());
        end
        if (sb.failures == 0)
            $display("set_associative_lru_tracker verification clean");
        else
            $display("set_associative_lru_tracker verification failed");
        $finish;
    end
endmodule
